@@ design/utf8_to_utf16_transcoder_assert.svh @@
// assertion macros for the utf8 to utf16 transcoder
// no dependencies; included by the top level
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define U8U16_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("u8u16 same-cycle check failed");
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("u8u16 next-cycle check failed");
`else
`define U8U16_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/u8u16_pkg.sv @@
// shared types, constants and decode helpers for the utf8 to utf16 transcoder
// no dependencies
package u8u16_pkg;

	typedef logic [15:0] unit_t;

	localparam int MaxUnits = 3;

	localparam unit_t UNIT_SUBST = 16'h007E;
	localparam unit_t UNIT_TERM  = 16'h0000;
	localparam logic [5:0] HI_SURR_TAG = 6'b110110;
	localparam logic [5:0] LO_SURR_TAG = 6'b110111;
	localparam logic [31:0] BMP_MAX   = 32'h0000FFFF;
	localparam logic [31:0] CP_MAX    = 32'h0010FFFF;
	localparam logic [20:0] PLANE1    = 21'h010000;

	typedef struct packed {
		logic [1:0]               count;
		logic [MaxUnits-1:0][15:0] unit;
		logic [MaxUnits-1:0]       eos;
	} unit_group_t;

	typedef struct packed {
		logic mid_seq;
	} dec_status_t;

	function automatic logic [2:0] trailing_of(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd0;
		if (b >= 8'hFC) n = 3'd5;
		else if (b >= 8'hF8) n = 3'd4;
		else if (b >= 8'hF0) n = 3'd3;
		else if (b >= 8'hE0) n = 3'd2;
		else if (b >= 8'hC0) n = 3'd1;
		return n;
	endfunction

	function automatic logic [31:0] seq_offset(input logic [2:0] n);
		logic [31:0] v;
		case (n)
			3'd1: v = 32'h00003080;
			3'd2: v = 32'h000E2080;
			3'd3: v = 32'h03C82080;
			3'd4: v = 32'hFA082080;
			3'd5: v = 32'h82082080;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

@@ design/u8u16_if.sv @@
// byte and code unit channel interfaces for the utf8 to utf16 transcoder
// no dependencies
interface u8u16_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       final_byte;

	modport source (output valid, output in_byte, output final_byte, input ready);
	modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

interface u8u16_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        end_of_string;

	modport source (output valid, output code_unit, output end_of_string, input ready);
	modport sink (input valid, input code_unit, input end_of_string, output ready);
endinterface

@@ design/u8u16_decode.sv @@
// sequence state and code point to code unit conversion for one byte
// depends on u8u16_pkg
module u8u16_decode (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  logic [7:0]               in_byte,
	input  logic                     final_byte,
	output u8u16_pkg::unit_group_t   group,
	output u8u16_pkg::dec_status_t   status
);
	import u8u16_pkg::*;

	logic [31:0] code_accum_q, acc_nx, acc_sh, cp;
	logic [2:0]  bytes_left_q, left_nx, seq_trailing_q, seq_nx, n;
	logic        cp_valid;
	logic [20:0] sv;
	logic [1:0]  k;

	always_comb begin
		acc_sh   = {code_accum_q[25:0], 6'b0} + {24'b0, in_byte};
		n        = trailing_of(in_byte);
		acc_nx   = code_accum_q;
		left_nx  = bytes_left_q;
		seq_nx   = seq_trailing_q;
		cp_valid = 1'b0;
		cp       = {24'b0, in_byte};
		if (bytes_left_q == 3'd0) begin
			if (n == 3'd0) begin
				cp_valid = 1'b1;
			end else begin
				acc_nx  = {24'b0, in_byte};
				seq_nx  = n;
				left_nx = n;
			end
		end else begin
			acc_nx  = acc_sh;
			left_nx = bytes_left_q - 3'd1;
			if (left_nx == 3'd0) begin
				cp_valid = 1'b1;
				cp       = acc_sh - seq_offset(seq_trailing_q);
				acc_nx   = 32'd0;
				seq_nx   = 3'd0;
			end
		end
	end

	always_comb begin
		sv    = cp[20:0] - PLANE1;
		group = '0;
		k     = 2'd0;
		if (cp_valid) begin
			if (cp <= BMP_MAX) begin
				group.unit[k] = cp[15:0];
				k = k + 2'd1;
			end else if (cp > CP_MAX) begin
				group.unit[k] = UNIT_SUBST;
				k = k + 2'd1;
			end else begin
				group.unit[k] = {HI_SURR_TAG, sv[19:10]};
				k = k + 2'd1;
				group.unit[k] = {LO_SURR_TAG, sv[9:0]};
				k = k + 2'd1;
			end
		end
		if (final_byte) begin
			if (left_nx != 3'd0) begin
				group.unit[k] = UNIT_SUBST;
				k = k + 2'd1;
			end
			group.unit[k] = UNIT_TERM;
			group.eos[k]  = 1'b1;
			k = k + 2'd1;
		end
		group.count = k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_accum_q   <= '0;
			bytes_left_q   <= '0;
			seq_trailing_q <= '0;
		end else if (advance) begin
			if (final_byte) begin
				code_accum_q   <= '0;
				bytes_left_q   <= '0;
				seq_trailing_q <= '0;
			end else begin
				code_accum_q   <= acc_nx;
				bytes_left_q   <= left_nx;
				seq_trailing_q <= seq_nx;
			end
		end
	end

	assign status.mid_seq = (bytes_left_q != 3'd0);
endmodule

@@ design/u8u16_outbuf.sv @@
// result register holding up to three code units, drained one word per cycle while the sink is ready
// depends on u8u16_pkg and u8u16_unit_if
module u8u16_outbuf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  u8u16_pkg::unit_group_t group,
	output logic                   free,
	u8u16_unit_if.source           units
);
	import u8u16_pkg::*;

	logic [MaxUnits-1:0][15:0] unit_q;
	logic [MaxUnits-1:0]       eos_q;
	logic [1:0]                cnt_q, rd_q;
	logic                      take;

	assign take                = units.valid && units.ready;
	assign units.valid         = (cnt_q != 2'd0);
	assign units.code_unit     = unit_q[rd_q];
	assign units.end_of_string = eos_q[rd_q];
	assign free                = (cnt_q == 2'd0) || (cnt_q == 2'd1 && units.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (load) begin
			cnt_q <= group.count;
			rd_q  <= '0;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unit_q <= group.unit;
			eos_q  <= group.eos;
		end
	end
endmodule

@@ design/utf8_to_utf16_transcoder.sv @@
// top level of the utf8 to utf16 transcoder: input register, decode, result register
// depends on u8u16_pkg, u8u16_if, u8u16_decode, u8u16_outbuf and the assertion header

// Takes one UTF-8 byte per word, final_byte set on the last byte of a string, and
// returns UTF-16 code units, each string closed by a zero unit with end_of_string
// set. A byte is taken every cycle while the sink is ready and each byte yields at
// most one unit; a byte that yields more (surrogate pair, substitute, terminator,
// up to three units) holds the input while the result register drains one unit
// per cycle to a ready sink. Lead bytes of multi-byte sequences yield no unit.
// Each byte passes the input register, then is decoded into the result register.
// Continuation bytes are not checked, extended five and six byte forms are decoded,
// code points above 0x10FFFF and strings cut inside a sequence give a '~' unit.
`include "utf8_to_utf16_transcoder_assert.svh"

module utf8_to_utf16_transcoder (
	input  logic          clk,
	input  logic          arst_n,
	u8u16_byte_if.sink    bytes,
	u8u16_unit_if.source  units
);
	import u8u16_pkg::*;

	logic        valid_s1, fin_s1;
	logic [7:0]  byte_s1;
	logic        buf_free, advance;
	unit_group_t group;
	dec_status_t status;

	assign advance     = valid_s1 && buf_free;
	assign bytes.ready = !valid_s1 || buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.in_byte;
			fin_s1  <= bytes.final_byte;
		end
	end

	u8u16_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.in_byte    (byte_s1),
		.final_byte (fin_s1),
		.group      (group),
		.status     (status)
	);

	u8u16_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.group  (group),
		.free   (buf_free),
		.units  (units)
	);

	`U8U16_ASSERT_NEXT(a_fin_clears_seq, clk, arst_n, advance && fin_s1, !status.mid_seq)
	`U8U16_ASSERT_NEXT(a_fin_gives_unit, clk, arst_n, advance && fin_s1, units.valid)
	`U8U16_ASSERT_SAME(a_term_is_zero, clk, arst_n, units.valid && units.end_of_string, units.code_unit == UNIT_TERM)
endmodule

@@ tb/utf8_to_utf16_transcoder_tb.sv @@
// testbench for utf8_to_utf16_transcoder: directed and random utf-8 strings, each decoded
// word checked against a predicted utf-16 unit stream, under varying idle and stall rates
// depends on u8u16_pkg, u8u16_if and the transcoder top level
module utf8_to_utf16_transcoder_tb;
	import u8u16_pkg::*;

	localparam logic [31:0] OFFSET_2B = 32'h00003080;
	localparam logic [31:0] OFFSET_3B = 32'h000E2080;
	localparam logic [31:0] OFFSET_4B = 32'h03C82080;
	localparam logic [31:0] OFFSET_5B = 32'hFA082080;
	localparam logic [31:0] OFFSET_6B = 32'h82082080;
	localparam logic [31:0] SUPP_BASE = 32'h00010000;
	localparam logic [15:0] HI_SURR_BASE = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
	localparam int MaxReports = 20;

	typedef struct {
		unit_t code_unit;
		logic  end_of_string;
	} unit_word_t;

	logic clk;
	logic arst_n;

	u8u16_byte_if bytes_ch ();
	u8u16_unit_if units_ch ();

	utf8_to_utf16_transcoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_ch),
		.units  (units_ch)
	);

	unit_word_t expected_units[$];
	int         mismatch_cnt;
	int         src_idle_pct;
	int         snk_stall_pct;

	logic [31:0] cp_acc;
	logic [2:0]  left_cnt;
	logic [2:0]  trail_cnt;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (mismatch_cnt < MaxReports)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	function automatic logic [2:0] lead_trailing(input logic [7:0] b);
		logic [2:0] n;
		casez (b)
			8'b0???_????, 8'b10??_????: n = 3'd0;
			8'b110?_????: n = 3'd1;
			8'b1110_????: n = 3'd2;
			8'b1111_0???: n = 3'd3;
			8'b1111_10??: n = 3'd4;
			default: n = 3'd5;
		endcase
		return n;
	endfunction

	function automatic logic [31:0] length_offset(input logic [2:0] n);
		case (n)
			3'd1: return OFFSET_2B;
			3'd2: return OFFSET_3B;
			3'd3: return OFFSET_4B;
			3'd4: return OFFSET_5B;
			3'd5: return OFFSET_6B;
			default: return 32'h0;
		endcase
	endfunction

	task automatic push_unit(input logic [15:0] u, input logic eos);
		unit_word_t w;
		w.code_unit = u;
		w.end_of_string = eos;
		expected_units.push_back(w);
	endtask

	task automatic push_code_point(input logic [31:0] cp);
		logic [31:0] v;
		if (cp <= BMP_MAX) begin
			push_unit(cp[15:0], 1'b0);
		end else if (cp > CP_MAX) begin
			push_unit(UNIT_SUBST, 1'b0);
		end else begin
			v = cp - SUPP_BASE;
			push_unit(v[25:10] + HI_SURR_BASE, 1'b0);
			push_unit({6'd0, v[9:0]} + LO_SURR_BASE, 1'b0);
		end
	endtask

	task automatic predict_units(input logic [7:0] b, input logic fin);
		logic [2:0] n;
		if (left_cnt == 3'd0) begin
			n = lead_trailing(b);
			if (n == 3'd0) begin
				push_code_point({24'd0, b});
			end else begin
				cp_acc = {24'd0, b};
				trail_cnt = n;
				left_cnt = n;
			end
		end else begin
			cp_acc = (cp_acc << 6) + {24'd0, b};
			left_cnt = left_cnt - 3'd1;
			if (left_cnt == 3'd0) begin
				push_code_point(cp_acc - length_offset(trail_cnt));
				cp_acc = 32'd0;
				trail_cnt = 3'd0;
			end
		end
		if (fin) begin
			if (left_cnt != 3'd0)
				push_unit(UNIT_SUBST, 1'b0);
			push_unit(UNIT_TERM, 1'b1);
			cp_acc = 32'd0;
			left_cnt = 3'd0;
			trail_cnt = 3'd0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < src_idle_pct) begin
			bytes_ch.valid <= 1'b0;
			@(posedge clk);
		end
		bytes_ch.valid <= 1'b1;
		bytes_ch.in_byte <= b;
		bytes_ch.final_byte <= fin;
		do @(posedge clk); while (!bytes_ch.ready);
		predict_units(b, fin);
	endtask

	task automatic send_string(input logic [7:0] s[$]);
		foreach (s[i])
			send_byte(s[i], i == s.size() - 1);
	endtask

	// one sequence of 1 to 6 bytes, continuation bytes mostly well formed
	task automatic append_sequence(inout logic [7:0] s[$], output int trail);
		logic [7:0] b;
		case ($urandom_range(5))
			0: b = 8'($urandom_range(127));
			1: b = {3'b110, 5'($urandom)};
			2: b = {4'b1110, 4'($urandom)};
			3: b = {5'b11110, 3'($urandom)};
			4: b = {6'b111110, 2'($urandom)};
			default: b = {6'b111111, 2'($urandom)};
		endcase
		trail = int'(lead_trailing(b));
		s.push_back(b);
		repeat (trail) begin
			if ($urandom_range(99) < 85)
				s.push_back({2'b10, 6'($urandom)});
			else
				s.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic send_random_strings(input int n_bytes);
		logic [7:0] s[$];
		int sent;
		int trail;
		int cut;
		sent = 0;
		while (sent < n_bytes) begin
			s.delete();
			trail = 0;
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(99) < 12) begin
					s.push_back(8'($urandom_range(255)));
					trail = 0;
				end else begin
					append_sequence(s, trail);
				end
			end
			if (trail > 0 && $urandom_range(99) < 15) begin
				cut = int'($urandom_range(1, trail));
				repeat (cut) void'(s.pop_back());
			end
			send_string(s);
			sent += s.size();
		end
	endtask

	task automatic test_directed();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		send_string('{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hC2, 8'hA9});
		send_string('{8'hEF, 8'hBF, 8'hBF});
		send_string('{8'hF0, 8'h9F, 8'h98, 8'h80});
		send_string('{8'hF4, 8'h90, 8'h80, 8'h80});
		send_string('{8'hFC, 8'h84, 8'h80, 8'h80, 8'h80, 8'h80});
		send_string('{8'hE2, 8'h82});
	endtask

	task automatic test_no_idle();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		send_random_strings(100);
	endtask

	task automatic test_source_idle();
		src_idle_pct = 79;
		snk_stall_pct = 0;
		send_random_strings(100);
	endtask

	task automatic test_sink_stall();
		src_idle_pct = 0;
		snk_stall_pct = 79;
		send_random_strings(100);
	endtask

	task automatic test_both_idle();
		src_idle_pct = 15;
		snk_stall_pct = 15;
		send_random_strings(100);
	endtask

	initial begin
		units_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			units_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		unit_word_t w;
		if (arst_n && units_ch.valid && units_ch.ready) begin
			if (expected_units.size() == 0) begin
				report_mismatch($sformatf("unexpected unit %h eos %b",
					units_ch.code_unit, units_ch.end_of_string));
			end else begin
				w = expected_units.pop_front();
				if (units_ch.code_unit !== w.code_unit)
					report_mismatch($sformatf("code_unit %h, expected %h",
						units_ch.code_unit, w.code_unit));
				if (units_ch.end_of_string !== w.end_of_string)
					report_mismatch($sformatf("end_of_string %b, expected %b",
						units_ch.end_of_string, w.end_of_string));
			end
		end
	end

	initial begin
		#2_400_000;
		$display("utf8_to_utf16_transcoder_tb: FAIL");
		$finish;
	end

	initial begin
		mismatch_cnt = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		cp_acc = 32'd0;
		left_cnt = 3'd0;
		trail_cnt = 3'd0;
		arst_n = 1'b0;
		bytes_ch.valid = 1'b0;
		bytes_ch.in_byte = 8'h00;
		bytes_ch.final_byte = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_no_idle();
		test_source_idle();
		test_sink_stall();
		test_both_idle();
		bytes_ch.valid <= 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		while (expected_units.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("utf8_to_utf16_transcoder_tb: PASS");
		else
			$display("utf8_to_utf16_transcoder_tb: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+design
design/u8u16_pkg.sv
design/u8u16_if.sv
design/u8u16_decode.sv
design/u8u16_outbuf.sv
design/utf8_to_utf16_transcoder.sv
tb/utf8_to_utf16_transcoder_tb.sv
